// File: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CHECK_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond at one edge implies expr at the next edge.
`define CHECK_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

// File: rtl/dpt_pkg.sv
`timescale 1ns / 1ps

package dpt_pkg;

    localparam int ADDR_W        = 32;
    localparam int PAGE_NUM_W    = 10;
    localparam int FRAME_NUM_W   = 8;
    localparam int LOG_BITS_W    = 6;
    localparam int PHYS_BITS_W   = 6;
    localparam int PAGE_BITS_W   = 5;
    localparam int CFG_DATA_W    = 6;
    localparam int CFG_INDEX_W   = 2;

    // Page table holds 2**PAGE_AW entries.
    localparam int DEF_PAGE_AW     = 10;
    localparam int DEF_MAX_FRAMES  = 256;

    localparam logic [LOG_BITS_W-1:0]  LOG_BITS_RST  = 6'd16;
    localparam logic [PHYS_BITS_W-1:0] PHYS_BITS_RST = 6'd16;
    localparam logic [PAGE_BITS_W-1:0] PAGE_BITS_RST = 5'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOG_BITS  = 2'd0,
        CFG_PHYS_BITS = 2'd1,
        CFG_PAGE_BITS = 2'd2
    } cfg_index_t;

    // All ones below bit n, n in 0..32.
    function automatic logic [ADDR_W-1:0] low_mask(input logic [5:0] n);
        logic [ADDR_W-1:0] m;
        begin
            if (n[5])
            begin
                m = '1;
            end
            else
            begin
                m = (ADDR_W'(1) << n[4:0]) - ADDR_W'(1);
            end
            return m;
        end
    endfunction

endpackage

// File: rtl/dpt_frame_table.sv
`timescale 1ns / 1ps

module dpt_frame_table #(
    parameter int PAGE_AW = 10,
    parameter int ENTRY_W = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    output logic               ready,
    input  logic               rd_en,
    input  logic [PAGE_AW-1:0] rd_idx,
    output logic [ENTRY_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [PAGE_AW-1:0] wr_idx,
    input  logic [ENTRY_W-1:0] wr_data
);

    logic [ENTRY_W-1:0] mem [2**PAGE_AW];
    logic [ENTRY_W-1:0] rd_q_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    logic [PAGE_AW-1:0] clr_idx_reg;
    logic               clr_busy_reg;

    // Sweep every entry to zero (unmapped) after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + PAGE_AW'(1);
            if (clr_idx_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_idx];
        end
    end

    // A write landing on the entry being read in the same cycle bypasses the array.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_idx == rd_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;
    assign ready   = !clr_busy_reg;

endmodule

// File: rtl/demand_page_translator_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Demand paging translator: one logical address word in, one translation word out.
// A new word is taken every cycle while in_stall is low, and its result passes through the
// input register, the page table read and the result register; the page table has a single
// read port and a single write port, with a write-to-read bypass. After reset the table is
// swept to unmapped (all 2**PAGE_AW entries, 1024 by default), during which in_stall stays
// high; configuration writes are taken then as always. A miss claims the next free frame in
// increasing order; once all frames are used, or the next frame number is too wide for
// phys_bits minus page_bits, a miss maps nothing and reports no_free_frame. Register
// writes keep existing mappings.
module demand_page_translator_core
    import dpt_pkg::*;
#(
    parameter int PAGE_AW    = DEF_PAGE_AW,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ADDR_W-1:0]      logical_address,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PAGE_NUM_W-1:0]  page_number,
    output logic [FRAME_NUM_W-1:0] frame_number,
    output logic [ADDR_W-1:0]      physical_address,
    output logic                   page_fault,
    output logic                   no_free_frame
);

    localparam int NF_W = $clog2(MAX_FRAMES + 1);

    logic [LOG_BITS_W-1:0]  log_bits_reg;
    logic [PHYS_BITS_W-1:0] phys_bits_reg;
    logic [PAGE_BITS_W-1:0] page_bits_reg;

    logic                   advance;
    logic                   tbl_ready;

    logic                   s1_valid_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic [5:0]             s1_lb;
    logic [ADDR_W-1:0]      s1_addr;
    logic [ADDR_W-1:0]      s1_page;
    logic [ADDR_W-1:0]      s1_offset;

    logic                   s2_valid_reg;
    logic [PAGE_NUM_W-1:0]  s2_page_reg;
    logic [ADDR_W-1:0]      s2_offset_reg;
    logic [PAGE_AW-1:0]     s2_idx_reg;

    logic [NF_W-1:0]        tbl_rd_data;
    logic [NF_W-1:0]        next_frame_reg;
    logic [NF_W-1:0]        next_frame_next;
    logic [5:0]             s2_pb;
    logic [5:0]             s2_exp;
    logic                   s2_hit;
    logic                   s2_free;
    logic                   s2_alloc;
    logic [NF_W-1:0]        s2_frame;
    logic [ADDR_W-1:0]      s2_frame32;
    logic [ADDR_W-1:0]      s2_phys;

    logic                   out_valid_reg;
    logic [PAGE_NUM_W-1:0]  out_page_reg;
    logic [FRAME_NUM_W-1:0] out_frame_reg;
    logic [ADDR_W-1:0]      out_phys_reg;
    logic                   out_fault_reg;
    logic                   out_nofree_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_bits_reg  <= LOG_BITS_RST;
            phys_bits_reg <= PHYS_BITS_RST;
            page_bits_reg <= PAGE_BITS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOG_BITS:  log_bits_reg  <= cfg_data;
                CFG_PHYS_BITS: phys_bits_reg <= cfg_data;
                CFG_PAGE_BITS: page_bits_reg <= cfg_data[PAGE_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipe moves together whenever the result register can take a word.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance || !tbl_ready;

    // Stage 1: split the address.
    always_comb
    begin
        s1_lb     = (log_bits_reg > 6'd32) ? 6'd32 : log_bits_reg;
        s1_addr   = s1_addr_reg & low_mask(s1_lb);
        s1_page   = s1_addr >> page_bits_reg;
        s1_offset = s1_addr & low_mask({1'b0, page_bits_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid && tbl_ready;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (in_valid && tbl_ready)
            begin
                s1_addr_reg <= logical_address;
            end
            s2_page_reg    <= s1_page[PAGE_NUM_W-1:0];
            s2_offset_reg  <= s1_offset;
            s2_idx_reg     <= s1_page[PAGE_AW-1:0];
            out_page_reg   <= s2_page_reg;
            out_frame_reg  <= s2_frame32[FRAME_NUM_W-1:0];
            out_phys_reg   <= s2_phys;
            out_fault_reg  <= !s2_hit;
            out_nofree_reg <= !s2_hit && !s2_free;
        end
    end

    dpt_frame_table #(
        .PAGE_AW (PAGE_AW),
        .ENTRY_W (NF_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (tbl_ready),
        .rd_en   (advance),
        .rd_idx  (s1_page[PAGE_AW-1:0]),
        .rd_data (tbl_rd_data),
        .wr_en   (advance && s2_alloc),
        .wr_idx  (s2_idx_reg),
        .wr_data (next_frame_reg + NF_W'(1))
    );

    // Stage 2: resolve hit or allocate. Entries hold frame + 1, zero when unmapped.
    always_comb
    begin
        s2_pb    = (phys_bits_reg > 6'd32) ? 6'd32 : phys_bits_reg;
        s2_exp   = (s2_pb > {1'b0, page_bits_reg}) ? (s2_pb - {1'b0, page_bits_reg}) : 6'd0;
        s2_hit   = (tbl_rd_data != '0);
        s2_free  = (next_frame_reg < NF_W'(MAX_FRAMES)) && ((next_frame_reg >> s2_exp) == '0);
        s2_alloc = s2_valid_reg && !s2_hit && s2_free;
        if (s2_hit)
        begin
            s2_frame = tbl_rd_data - NF_W'(1);
        end
        else if (s2_free)
        begin
            s2_frame = next_frame_reg;
        end
        else
        begin
            s2_frame = '0;
        end
        s2_frame32 = ADDR_W'(s2_frame);
        if (!s2_hit && !s2_free)
        begin
            s2_phys = '0;
        end
        else
        begin
            s2_phys = (s2_frame32 << page_bits_reg) | s2_offset_reg;
        end
        next_frame_next = (advance && s2_alloc) ? next_frame_reg + NF_W'(1) : next_frame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_frame_reg <= '0;
        end
        else
        begin
            next_frame_reg <= next_frame_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign page_number      = out_page_reg;
    assign frame_number     = out_frame_reg;
    assign physical_address = out_phys_reg;
    assign page_fault       = out_fault_reg;
    assign no_free_frame    = out_nofree_reg;

    `CHECK_CLK(a_frame_cap, next_frame_reg <= NF_W'(MAX_FRAMES), "frame counter past frame count")
    `CHECK_CLK(a_frame_step,
        (next_frame_reg != $past(next_frame_reg))
            |-> (next_frame_reg == $past(next_frame_reg) + NF_W'(1)),
        "frame counter skipped")
    `CHECK_CLK(a_nofree_fault, (out_valid_reg && out_nofree_reg) |-> out_fault_reg,
        "no_free_frame without page_fault")
    `CHECK_NEXT(a_full_no_alloc, advance && s2_valid_reg && !s2_free,
        $stable(next_frame_reg), "frame allocated with none free")

endmodule
